/* design/twq_pkg.sv */
package twq_pkg;

    // Field widths of the request and result channels
    localparam int ACTION_W    = 1;
    localparam int TAG_FIELD_W = 6;
    localparam int DELAY_W     = 6;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_INSERT = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 1'b1;

    // Result kinds
    localparam logic KIND_WOKEN  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

endpackage

/* design/twq_if.sv */
interface twq_req_if;
    import twq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [TAG_FIELD_W-1:0] item_tag;
    logic [DELAY_W-1:0]     delay;

    modport source (output valid, action, item_tag, delay, input ready);
    modport sink   (input valid, action, item_tag, delay, output ready);
endinterface

interface twq_rsp_if;
    import twq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [TAG_FIELD_W-1:0] woken_tag;
    logic                   last;

    modport source (output valid, kind, woken_tag, last, input ready);
    modport sink   (input valid, kind, woken_tag, last, output ready);
endinterface

/* design/timing_wheel_event_queue.sv */
// Sequence: an insert reads its target slot, then appends the tag to its list; a tick reads
// the next slot, clears it if occupied and offers each woken tag in turn; a rejected insert
// gives its result in the cycle after the request is taken. Throughput: one request at a
// time; the slot table has one read and one write port and the tag list is walked one link
// per memory read. Reset: asynchronous, active low; afterwards a clearing pass marks every
// slot empty before the first request is taken.
module timing_wheel_event_queue #(
    parameter int SLOT_COUNT = 64,
    parameter int TAG_COUNT  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    twq_req_if.sink     req,
    twq_rsp_if.source   rsp
);
    import twq_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int TAG_W  = $clog2(TAG_COUNT);
    localparam int SUM_W  = ((SLOT_W > DELAY_W) ? SLOT_W : DELAY_W) + 1;
    localparam int TAGX_W = TAG_FIELD_W + 1;
    // Slot table entry: {occupied, head, tail}
    localparam int ENT_W  = 1 + 2 * TAG_W;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_INS   = 6'b000100,
        ST_TICK  = 6'b001000,
        ST_EMIT  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    // Sequencer and datapath registers
    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      cur_reg, cur_next;
    logic [SLOT_W-1:0]      clr_reg, clr_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [TAG_W-1:0]       tail_reg, tail_next;
    logic [TAG_COUNT-1:0]   pending_reg, pending_next;
    logic                   kind_reg, kind_next;
    logic [TAG_FIELD_W-1:0] otag_reg, otag_next;
    logic                   last_reg, last_next;

    // Memories and their ports
    logic [ENT_W-1:0]       slot_mem [SLOT_COUNT];
    logic [TAG_W-1:0]       link_mem [TAG_COUNT];
    logic [ENT_W-1:0]       ent_rd_reg;
    logic [TAG_W-1:0]       link_rd_reg;
    logic                   slot_we;
    logic [SLOT_W-1:0]      slot_waddr;
    logic [SLOT_W-1:0]      slot_raddr;
    logic [ENT_W-1:0]       slot_wdata;
    logic                   link_we;
    logic [TAG_W-1:0]       link_waddr;

    // Request decode
    logic                   req_fire;
    logic                   delay_ok;
    logic                   tag_ok;
    logic                   insert_ok;
    logic [SUM_W-1:0]       ins_sum;
    logic [SLOT_W-1:0]      ins_slot;
    logic [SLOT_W-1:0]      tick_slot;
    logic                   ent_occ;
    logic [TAG_W-1:0]       ent_head;
    logic [TAG_W-1:0]       ent_tail;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid     = (state_reg == ST_OUT);
    assign rsp.kind      = kind_reg;
    assign rsp.woken_tag = otag_reg;
    assign rsp.last      = last_reg;

    // Reject a zero delay, one that reaches round the whole wheel, or a bad or pending tag
    assign delay_ok  = (req.delay != '0) && (SUM_W'(req.delay) < SUM_W'(SLOT_COUNT));
    assign tag_ok    = ({1'b0, req.item_tag} < TAGX_W'(TAG_COUNT));
    assign insert_ok = delay_ok && tag_ok && !pending_reg[req.item_tag[TAG_W-1:0]];

    // Both operands stay below SLOT_COUNT, so one compare and subtract wraps the sum
    assign ins_sum  = SUM_W'(cur_reg) + SUM_W'(req.delay);
    assign ins_slot = (ins_sum >= SUM_W'(SLOT_COUNT)) ?
                      SLOT_W'(ins_sum - SUM_W'(SLOT_COUNT)) : SLOT_W'(ins_sum);
    assign tick_slot = (cur_reg == SLOT_W'(SLOT_COUNT - 1)) ? '0 : cur_reg + SLOT_W'(1);

    assign ent_occ  = ent_rd_reg[ENT_W-1];
    assign ent_head = ent_rd_reg[2*TAG_W-1:TAG_W];
    assign ent_tail = ent_rd_reg[TAG_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        clr_next     = clr_reg;
        slot_next    = slot_reg;
        tag_next     = tag_reg;
        tail_next    = tail_reg;
        pending_next = pending_reg;
        kind_next    = kind_reg;
        otag_next    = otag_reg;
        last_next    = last_reg;
        slot_we      = 1'b0;
        slot_waddr   = slot_reg;
        slot_wdata   = '0;
        slot_raddr   = slot_reg;
        link_we      = 1'b0;
        link_waddr   = ent_tail;

        case (state_reg)
            ST_CLEAR:
            begin
                // Mark one slot empty per cycle
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                clr_next   = clr_reg + SLOT_W'(1);
                if (clr_reg == SLOT_W'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.action == ACT_TICK)
                    begin
                        cur_next   = tick_slot;
                        slot_next  = tick_slot;
                        slot_raddr = tick_slot;
                        state_next = ST_TICK;
                    end
                    else if (!insert_ok)
                    begin
                        kind_next  = KIND_REJECT;
                        otag_next  = req.item_tag;
                        last_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        slot_next  = ins_slot;
                        slot_raddr = ins_slot;
                        tag_next   = req.item_tag[TAG_W-1:0];
                        state_next = ST_INS;
                    end
                end
            end
            ST_INS:
            begin
                // Append to the tail, or start a fresh list in an empty slot
                link_we    = ent_occ;
                slot_we    = 1'b1;
                slot_wdata = {1'b1, (ent_occ ? ent_head : tag_reg), tag_reg};
                pending_next[tag_reg] = 1'b1;
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                if (!ent_occ)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {1'b0, ent_head, ent_tail};
                    tag_next   = ent_head;
                    tail_next  = ent_tail;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                kind_next  = KIND_WOKEN;
                otag_next  = TAG_FIELD_W'(tag_reg);
                last_next  = (tag_reg == tail_reg);
                pending_next[tag_reg] = 1'b0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Follow the link read while the result waited
                        tag_next   = link_rd_reg;
                        state_next = ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cur_reg     <= '0;
            clr_reg     <= '0;
            pending_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            clr_reg     <= clr_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        tag_reg  <= tag_next;
        tail_reg <= tail_next;
        kind_reg <= kind_next;
        otag_reg <= otag_next;
        last_reg <= last_next;
    end

    // Slot table: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        ent_rd_reg <= slot_mem[slot_raddr];
    end

    // Next links: written on append, read at the tag being drained
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= tag_reg;
        end
        link_rd_reg <= link_mem[tag_reg];
    end

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(cur_reg) < SUM_W'(SLOT_COUNT))
        else $error("current slot beyond the wheel");

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.kind == KIND_REJECT) |-> rsp.last)
        else $error("rejected insert not marked last");

    a_zero_delay_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req.action == ACT_INSERT) && (req.delay == '0)
        |=> rsp.valid && (rsp.kind == KIND_REJECT) && rsp.last)
        else $error("zero delay insert not rejected");

    a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && (req.action == ACT_TICK) |=> cur_reg != $past(cur_reg))
        else $error("tick did not advance the wheel");

    a_woken_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.kind == KIND_WOKEN) |-> !pending_reg[rsp.woken_tag[TAG_W-1:0]])
        else $error("woken tag still marked pending");

endmodule

/* sim/tb_timing_wheel_event_queue.sv */
`timescale 1ns / 1ps

module tb_timing_wheel_event_queue;
    import twq_pkg::*;

    localparam int SLOTS          = 64;
    localparam int TAGS           = 64;
    localparam int HOLD_CYCLES    = 600;   // long receiver hold-off, forces a stall
    localparam int WATCHDOG_LIMIT = 4000;  // idle cycles tolerated before giving up
    localparam int SETTLE_CYCLES  = 16;    // quiet time after the last result
    localparam int PLAN_LEN       = 22;

    // One result as the block reports it
    typedef struct packed {
        logic                   kind;
        logic [TAG_FIELD_W-1:0] tag;
        logic                   last;
    } wake_t;

    // One row of the directed plan; typed rows carry their own expectation
    typedef struct packed {
        logic                   act;
        logic [TAG_FIELD_W-1:0] tag;
        logic [DELAY_W-1:0]     dly;
        logic                   typed;
        logic                   one_res;
        wake_t                  res;
    } plan_row_t;

    localparam wake_t NO_RES = '0;

    logic clk;
    logic rst_n;

    twq_req_if req_ch ();
    twq_rsp_if rsp_ch ();

    timing_wheel_event_queue #(
        .SLOT_COUNT (SLOTS),
        .TAG_COUNT  (TAGS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Period 8 ns
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the wheel: current slot, per-slot FIFO lists threaded
    // through per-tag links, and the set of tags still waiting.
    // ------------------------------------------------------------------
    logic [5:0] wheel_pos;
    bit         slot_busy   [SLOTS];
    logic [5:0] slot_first  [SLOTS];
    logic [5:0] slot_final  [SLOTS];
    logic [5:0] tag_next    [TAGS];
    bit         tag_waiting [TAGS];

    wake_t fresh_q [$];   // results of the request just taken
    wake_t wake_q  [$];   // results still owed by the block, oldest first

    // Apply one request to the shadow wheel and leave its results in fresh_q
    function automatic void step_wheel(input logic act, input logic [5:0] tg,
                                       input logic [5:0] dl);
        logic [5:0] slot;
        logic [5:0] walk;
        bit         at_end;
        fresh_q.delete();
        if (act == ACT_INSERT)
        begin
            // Reject a zero delay or a tag that is already on the wheel; state holds
            if (dl == '0 || tag_waiting[tg])
            begin
                fresh_q.push_back(wake_t'{KIND_REJECT, tg, 1'b1});
                return;
            end
            slot = wheel_pos + dl;   // six bits wrap at the wheel size
            if (!slot_busy[slot])
            begin
                slot_busy[slot]  = 1'b1;
                slot_first[slot] = tg;
            end
            else
            begin
                tag_next[slot_final[slot]] = tg;
            end
            slot_final[slot] = tg;
            tag_waiting[tg]  = 1'b1;
        end
        else
        begin
            // Advance first, then drain the slot just reached
            wheel_pos = wheel_pos + 6'd1;
            if (!slot_busy[wheel_pos])
                return;
            slot_busy[wheel_pos] = 1'b0;
            walk = slot_first[wheel_pos];
            for (int n = 0; n < TAGS; n++)
            begin
                at_end = (walk == slot_final[wheel_pos]);
                tag_waiting[walk] = 1'b0;
                fresh_q.push_back(wake_t'{KIND_WOKEN, walk, at_end});
                if (at_end)
                    break;
                walk = tag_next[walk];
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed plan. Rows with typed set hold an expectation that can be
    // read straight off the behaviour; the rest rely on the shadow wheel.
    // Slot numbers in the notes are the target slots.
    // ------------------------------------------------------------------
    plan_row_t plan [PLAN_LEN] = '{
        // tick straight after reset: slot 1 is empty, nothing comes back
        '{ACT_TICK,   6'd0,  6'd0,  1'b1, 1'b0, NO_RES},
        // zero delay is refused
        '{ACT_INSERT, 6'd0,  6'd0,  1'b1, 1'b1, wake_t'{KIND_REJECT, 6'd0, 1'b1}},
        // largest tag, largest delay: wraps round to slot 0, silent
        '{ACT_INSERT, 6'd63, 6'd63, 1'b1, 1'b0, NO_RES},
        // same tag again while still waiting is refused
        '{ACT_INSERT, 6'd63, 6'd1,  1'b1, 1'b1, wake_t'{KIND_REJECT, 6'd63, 1'b1}},
        // three tags queued into slot 2, one stray into slot 43
        '{ACT_INSERT, 6'd0,  6'd1,  1'b0, 1'b0, NO_RES},
        '{ACT_INSERT, 6'd21, 6'd42, 1'b0, 1'b0, NO_RES},
        '{ACT_INSERT, 6'd42, 6'd1,  1'b0, 1'b0, NO_RES},
        '{ACT_INSERT, 6'd5,  6'd1,  1'b0, 1'b0, NO_RES},
        // drain slot 2 in insertion order; tag and delay fields are ignored
        '{ACT_TICK,   6'd63, 6'd63, 1'b0, 1'b0, NO_RES},
        // slot 3 is empty
        '{ACT_TICK,   6'd0,  6'd0,  1'b1, 1'b0, NO_RES},
        // wrap round: a fresh head into slot 2, two refusals, then two tags into slot 1
        '{ACT_INSERT, 6'd0,  6'd63, 1'b0, 1'b0, NO_RES},
        '{ACT_INSERT, 6'd0,  6'd5,  1'b1, 1'b1, wake_t'{KIND_REJECT, 6'd0, 1'b1}},
        '{ACT_INSERT, 6'd42, 6'd0,  1'b1, 1'b1, wake_t'{KIND_REJECT, 6'd42, 1'b1}},
        '{ACT_INSERT, 6'd1,  6'd62, 1'b0, 1'b0, NO_RES},
        '{ACT_INSERT, 6'd2,  6'd62, 1'b0, 1'b0, NO_RES},
        // a single tag in slot 4, woken alone and marked last
        '{ACT_INSERT, 6'd7,  6'd1,  1'b0, 1'b0, NO_RES},
        '{ACT_TICK,   6'd0,  6'd0,  1'b1, 1'b1, wake_t'{KIND_WOKEN, 6'd7, 1'b1}},
        // a woken tag may be scheduled again straight away
        '{ACT_INSERT, 6'd7,  6'd2,  1'b0, 1'b0, NO_RES},
        '{ACT_TICK,   6'd0,  6'd0,  1'b1, 1'b0, NO_RES},
        '{ACT_TICK,   6'd0,  6'd0,  1'b1, 1'b1, wake_t'{KIND_WOKEN, 6'd7, 1'b1}},
        '{ACT_INSERT, 6'd62, 6'd1,  1'b0, 1'b0, NO_RES},
        '{ACT_TICK,   6'd0,  6'd0,  1'b0, 1'b0, NO_RES}
    };

    // Idling rates, in cycles of a hundred
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int          hold_asks;     // bumped by the stimulus to ask for a long hold-off

    int failures;
    int n_inserts;
    int n_ticks;
    int n_rejects;
    int n_results;
    int widest_drain;

    // ------------------------------------------------------------------
    // Offer one request, wait for it to be taken, then book its results.
    // Valid is left high on return so back-to-back requests never lower
    // and raise it in the same step.
    // ------------------------------------------------------------------
    task automatic offer_request(input logic act, input logic [5:0] tg, input logic [5:0] dl,
                                 input logic typed, input logic one_res, input wake_t res);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.item_tag <= tg;
        req_ch.delay    <= dl;
        do
            @(posedge clk);
        while (!req_ch.ready);

        // Taken at this edge: keep the shadow wheel in step even on typed rows
        step_wheel(act, tg, dl);
        if (typed)
        begin
            if (one_res)
                wake_q.push_back(res);
        end
        else
        begin
            foreach (fresh_q[i])
                wake_q.push_back(fresh_q[i]);
        end

        if (act == ACT_TICK)
        begin
            n_ticks++;
            if (fresh_q.size() > widest_drain)
                widest_drain = fresh_q.size();
        end
        else
        begin
            n_inserts++;
            if (fresh_q.size() != 0)
                n_rejects++;
        end
    endtask

    // Draw one random request. Most are well formed: ticks, or inserts of a
    // free tag with a mostly short delay so that slots fill and drain often. The
    // rest is noise: any tag, zero or arbitrary delay.
    task automatic draw_request(output logic act, output logic [5:0] tg,
                                output logic [5:0] dl);
        int unsigned pick;
        int unsigned start;
        bit          found;
        pick  = $urandom_range(0, 99);
        act   = ACT_TICK;
        tg    = 6'($urandom_range(0, TAGS - 1));
        dl    = 6'($urandom_range(0, 63));
        found = 1'b0;
        if (pick < 40)
            return;
        if (pick < 85)
        begin
            start = $urandom_range(0, TAGS - 1);
            for (int k = 0; k < TAGS; k++)
            begin
                if (!found && !tag_waiting[(start + k) % TAGS])
                begin
                    tg    = 6'((start + k) % TAGS);
                    found = 1'b1;
                end
            end
            if (found)
            begin
                act = ACT_INSERT;
                dl  = ($urandom_range(0, 3) != 0) ? 6'($urandom_range(1, 6))
                                                  : 6'($urandom_range(1, 63));
            end
            return;
        end
        act = ACT_INSERT;
        if ($urandom_range(0, 2) == 0)
            dl = '0;
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_ready_drive
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                // Hold off: let the block back up and stall its request side
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking: every result taken must match the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        wake_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            n_results++;
            if (wake_q.size() == 0)
            begin
                $error("unexpected result: kind %0d, woken_tag %0d, last %0d",
                       rsp_ch.kind, rsp_ch.woken_tag, rsp_ch.last);
                failures++;
            end
            else
            begin
                want = wake_q.pop_front();
                if (rsp_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, rsp_ch.kind);
                    failures++;
                end
                if (rsp_ch.woken_tag !== want.tag)
                begin
                    $error("woken_tag: expected %0d, got %0d", want.tag, rsp_ch.woken_tag);
                    failures++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up after a long run of cycles with no handshake at all
    // ------------------------------------------------------------------
    int quiet_cycles;

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results still owed", wake_q.size());
            $display("timing_wheel_event_queue: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic       act;
        logic [5:0] tg;
        logic [5:0] dl;
        logic [5:0] burst_delay;
        logic [5:0] tag_order [TAGS];
        logic [5:0] swap;
        int         j;
        bit         busy;

        failures     = 0;
        n_inserts    = 0;
        n_ticks      = 0;
        n_rejects    = 0;
        n_results    = 0;
        widest_drain = 0;
        src_idle_pct = 35;
        wheel_pos    = '0;
        for (int s = 0; s < SLOTS; s++)
            slot_busy[s] = 1'b0;
        for (int t = 0; t < TAGS; t++)
            tag_waiting[t] = 1'b0;

        hold_asks       <= 0;
        snk_idle_pct    <= 46;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.action   <= ACT_INSERT;
        req_ch.item_tag <= '0;
        req_ch.delay    <= '0;

        // Hold reset, then release it; the clearing pass afterwards shows up as
        // ready staying low, which the handshake simply waits out
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed plan, with the sender idling 35 in 100 and the receiver 46
        foreach (plan[r])
            offer_request(plan[r].act, plan[r].tag, plan[r].dly,
                          plan[r].typed, plan[r].one_res, plan[r].res);

        // Random part, same idling
        repeat (25)
        begin
            draw_request(act, tg, dl);
            offer_request(act, tg, dl, 1'b0, 1'b0, NO_RES);
        end

        // Swap the idling rates round
        src_idle_pct = 46;
        snk_idle_pct <= 35;
        repeat (25)
        begin
            draw_request(act, tg, dl);
            offer_request(act, tg, dl, 1'b0, 1'b0, NO_RES);
        end

        // No idling from here on. Tick until the wheel is empty so that every
        // tag is free for the full-slot burst.
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        forever
        begin
            busy = 1'b0;
            foreach (tag_waiting[t])
                busy |= tag_waiting[t];
            if (!busy)
                break;
            offer_request(ACT_TICK, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          1'b0, 1'b0, NO_RES);
        end

        // Ask the receiver for a long hold-off, then pile every tag into one
        // slot in shuffled order. The tick that reaches it owes all of them,
        // the block backs up, and the requests after it stall.
        hold_asks <= hold_asks + 1;
        for (int t = 0; t < TAGS; t++)
            tag_order[t] = 6'(t);
        for (int t = TAGS - 1; t > 0; t--)
        begin
            j            = $urandom_range(0, t);
            swap         = tag_order[t];
            tag_order[t] = tag_order[j];
            tag_order[j] = swap;
        end
        burst_delay = 6'($urandom_range(1, 4));
        foreach (tag_order[t])
            offer_request(ACT_INSERT, tag_order[t], burst_delay, 1'b0, 1'b0, NO_RES);
        repeat (burst_delay)
            offer_request(ACT_TICK, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                          1'b0, 1'b0, NO_RES);

        // Keep offering through the hold-off
        repeat (10)
        begin
            draw_request(act, tg, dl);
            offer_request(act, tg, dl, 1'b0, 1'b0, NO_RES);
        end
        req_ch.valid <= 1'b0;

        // Wait for every owed result, then a quiet spell to catch strays;
        // the watchdog covers a block that never delivers
        while (wake_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d inserts (%0d refused), %0d ticks",
                 n_inserts + n_ticks, n_inserts, n_rejects, n_ticks);
        $display("checked %0d results; widest single drain %0d tags, long receiver stall",
                 n_results, widest_drain);
        if (failures == 0)
            $display("timing_wheel_event_queue: match");
        else
            $display("timing_wheel_event_queue: mismatch");
        $finish;
    end

endmodule
